/* design/vcrf_pkg.sv */
// Shared constants and register codes for the view-cone range filter.
package vcrf_pkg;

    localparam int ID_BITS           = 32;
    localparam int COORD_BITS_DEF    = 32;
    localparam int DIR_FRAC_BITS_DEF = 14;
    localparam int CFG_IDX_BITS      = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_OBS_X       = 3'd0,
        REG_OBS_Y       = 3'd1,
        REG_OBS_Z       = 3'd2,
        REG_FACE_X      = 3'd3,
        REG_FACE_Y      = 3'd4,
        REG_FACE_Z      = 3'd5,
        REG_RANGE_LIMIT = 3'd6,
        REG_VIEW_COS    = 3'd7
    } t_cfg_reg;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* design/vcrf_front.sv */
// Front end: offset, magnitudes, squares, facing products and their sums.
module vcrf_front #(
    parameter int C = vcrf_pkg::COORD_BITS_DEF,
    parameter int U = vcrf_pkg::DIR_FRAC_BITS_DEF + 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [vcrf_pkg::ID_BITS-1:0]  i_observer_id,
    input  logic [vcrf_pkg::ID_BITS-1:0]  i_target_id,
    input  logic signed [C-1:0]           i_tgt_x,
    input  logic signed [C-1:0]           i_tgt_y,
    input  logic signed [C-1:0]           i_tgt_z,
    input  logic                          i_last_in,
    input  logic signed [C-1:0]           i_obs_x,
    input  logic signed [C-1:0]           i_obs_y,
    input  logic signed [C-1:0]           i_obs_z,
    input  logic signed [U-1:0]           i_face_x,
    input  logic signed [U-1:0]           i_face_y,
    input  logic signed [U-1:0]           i_face_z,
    output logic                          o_valid,
    output logic [2*(C+1)-1:0]            o_rad,
    output logic signed [U+C+2:0]         o_dot,
    output logic [C:0]                    o_mag_x,
    output logic [C:0]                    o_mag_y,
    output logic [C:0]                    o_mag_z,
    output logic                          o_neg_x,
    output logic                          o_neg_y,
    output logic                          o_neg_z,
    output logic [vcrf_pkg::ID_BITS-1:0]  o_tid,
    output logic                          o_last,
    output logic                          o_idne
);
    localparam int N      = C + 1;
    localparam int SQ_W   = 2 * N;
    localparam int PROD_W = U + N;
    localparam int DOT_W  = U + N + 2;

    function automatic logic [N-1:0] f_mag(input logic signed [N-1:0] v);
        logic [N-1:0] u;
        u = v;
        return v[N-1] ? (~u + N'(1)) : u;
    endfunction

    // Stage 1: offsets.
    logic                         r1_vld;
    logic signed [N-1:0]          r1_dx, r1_dy, r1_dz;
    logic [vcrf_pkg::ID_BITS-1:0] r1_tid;
    logic                         r1_last, r1_idne;

    // Stage 2: squares and facing products.
    logic                         r2_vld;
    logic [SQ_W-1:0]              r2_sqx, r2_sqy, r2_sqz;
    logic signed [PROD_W-1:0]     r2_px, r2_py, r2_pz;
    logic [N-1:0]                 r2_mx, r2_my, r2_mz;
    logic                         r2_nx, r2_ny, r2_nz;
    logic [vcrf_pkg::ID_BITS-1:0] r2_tid;
    logic                         r2_last, r2_idne;

    // Stage 3: sums.
    logic                         r3_vld;
    logic [SQ_W-1:0]              r3_rad;
    logic signed [DOT_W-1:0]      r3_dot;
    logic [N-1:0]                 r3_mx, r3_my, r3_mz;
    logic                         r3_nx, r3_ny, r3_nz;
    logic [vcrf_pkg::ID_BITS-1:0] r3_tid;
    logic                         r3_last, r3_idne;

    logic [N-1:0] n2_mx, n2_my, n2_mz;

    assign n2_mx = f_mag(r1_dx);
    assign n2_my = f_mag(r1_dy);
    assign n2_mz = f_mag(r1_dz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dx   <= N'(i_tgt_x) - N'(i_obs_x);
        r1_dy   <= N'(i_tgt_y) - N'(i_obs_y);
        r1_dz   <= N'(i_tgt_z) - N'(i_obs_z);
        r1_tid  <= i_target_id;
        r1_last <= i_last_in;
        r1_idne <= (i_observer_id != i_target_id);

        r2_sqx  <= SQ_W'(n2_mx) * SQ_W'(n2_mx);
        r2_sqy  <= SQ_W'(n2_my) * SQ_W'(n2_my);
        r2_sqz  <= SQ_W'(n2_mz) * SQ_W'(n2_mz);
        r2_px   <= PROD_W'(i_face_x) * PROD_W'(r1_dx);
        r2_py   <= PROD_W'(i_face_y) * PROD_W'(r1_dy);
        r2_pz   <= PROD_W'(i_face_z) * PROD_W'(r1_dz);
        r2_mx   <= n2_mx;
        r2_my   <= n2_my;
        r2_mz   <= n2_mz;
        r2_nx   <= r1_dx[N-1];
        r2_ny   <= r1_dy[N-1];
        r2_nz   <= r1_dz[N-1];
        r2_tid  <= r1_tid;
        r2_last <= r1_last;
        r2_idne <= r1_idne;

        r3_rad  <= r2_sqx + r2_sqy + r2_sqz;
        r3_dot  <= DOT_W'(r2_px) + DOT_W'(r2_py) + DOT_W'(r2_pz);
        r3_mx   <= r2_mx;
        r3_my   <= r2_my;
        r3_mz   <= r2_mz;
        r3_nx   <= r2_nx;
        r3_ny   <= r2_ny;
        r3_nz   <= r2_nz;
        r3_tid  <= r2_tid;
        r3_last <= r2_last;
        r3_idne <= r2_idne;
    end

    assign o_valid = r3_vld;
    assign o_rad   = r3_rad;
    assign o_dot   = r3_dot;
    assign o_mag_x = r3_mx;
    assign o_mag_y = r3_my;
    assign o_mag_z = r3_mz;
    assign o_neg_x = r3_nx;
    assign o_neg_y = r3_ny;
    assign o_neg_z = r3_nz;
    assign o_tid   = r3_tid;
    assign o_last  = r3_last;
    assign o_idne  = r3_idne;

endmodule

/* design/vcrf_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module vcrf_isqrt #(
    parameter int N      = vcrf_pkg::COORD_BITS_DEF + 1,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2*N-1:0]    i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [N-1:0]      o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int REM_W = N + 3;

    logic              s_vld  [N];
    logic [REM_W-1:0]  s_rem  [N];
    logic [N-1:0]      s_root [N];
    logic [2*N-1:0]    s_rad  [N];
    logic [SIDE_W-1:0] s_side [N];

    logic [REM_W-1:0]  n_rem  [N];
    logic [N-1:0]      n_root [N];

    logic              r_vld  [N];
    logic [REM_W-1:0]  r_rem  [N];
    logic [N-1:0]      r_root [N];
    logic [2*N-1:0]    r_rad  [N];
    logic [SIDE_W-1:0] r_side [N];

    always_comb begin
        s_vld[0]  = i_valid;
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_rad[0]  = i_rad;
        s_side[0] = i_side;
        for (int k = 1; k < N; k++) begin
            s_vld[k]  = r_vld[k-1];
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
            s_rad[k]  = r_rad[k-1];
            s_side[k] = r_side[k-1];
        end
    end

    // Bring down two radicand bits and try to subtract 4*root + 1.
    always_comb begin
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] trial;
        logic             ge;
        for (int k = 0; k < N; k++) begin
            t         = {s_rem[k][N:0], s_rad[k][2*N-1 -: 2]};
            trial     = {1'b0, s_root[k], 2'b01};
            ge        = (t >= trial);
            n_rem[k]  = ge ? (t - trial) : t;
            n_root[k] = {s_root[k][N-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < N; k++) begin
                r_vld[k] <= s_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
            r_rad[k]  <= s_rad[k] << 2;
            r_side[k] <= s_side[k];
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

/* design/vcrf_div.sv */
// Pipelined three-lane restoring divider for the unit direction quotients.
module vcrf_div #(
    parameter int N      = vcrf_pkg::COORD_BITS_DEF + 1,
    parameter int D      = vcrf_pkg::DIR_FRAC_BITS_DEF,
    parameter int SIDE_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [N-1:0]         i_len,
    input  logic [2:0][N-1:0]    i_mag,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [N-1:0]         o_len,
    output logic [2:0][D:0]      o_q,
    output logic [2:0][N-1:0]    o_rem,
    output logic [SIDE_W-1:0]    o_side
);
    localparam int ST = D + 1;

    logic                 r_vld  [ST];
    logic [N-1:0]         r_len  [ST];
    logic [2:0][D:0]      r_q    [ST];
    logic [2:0][N-1:0]    r_rem  [ST];
    logic [SIDE_W-1:0]    r_side [ST];

    logic [2:0][D:0]      n_q    [ST];
    logic [2:0][N-1:0]    n_rem  [ST];

    // First stage takes the integer bit; each later stage one fraction bit.
    always_comb begin
        logic [N:0] t;
        logic       ge;
        for (int j = 0; j < 3; j++) begin
            ge          = (i_mag[j] >= i_len);
            n_q[0][j]   = (D+1)'(ge);
            n_rem[0][j] = ge ? (i_mag[j] - i_len) : i_mag[j];
        end
        for (int k = 1; k < ST; k++) begin
            for (int j = 0; j < 3; j++) begin
                t           = {r_rem[k-1][j], 1'b0};
                ge          = (t >= {1'b0, r_len[k-1]});
                n_rem[k][j] = ge ? N'(t - {1'b0, r_len[k-1]}) : N'(t);
                n_q[k][j]   = {r_q[k-1][j][D-1:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < ST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len[0]  <= i_len;
        r_side[0] <= i_side;
        for (int k = 1; k < ST; k++) begin
            r_len[k]  <= r_len[k-1];
            r_side[k] <= r_side[k-1];
        end
        for (int k = 0; k < ST; k++) begin
            r_q[k]   <= n_q[k];
            r_rem[k] <= n_rem[k];
        end
    end

    assign o_valid = r_vld[ST-1];
    assign o_len   = r_len[ST-1];
    assign o_q     = r_q[ST-1];
    assign o_rem   = r_rem[ST-1];
    assign o_side  = r_side[ST-1];

endmodule

/* design/view_cone_range_filter.sv */
// Top level of the view-cone range filter: registers, compare, rounding, outputs.
//
// Usage: the observer position, facing vector, range limit and view cosine are
// written through the configuration channel (i_cfg_valid, o_cfg_ready,
// i_cfg_index, i_cfg_data); o_cfg_ready is always high, so a write lands on
// every cycle in which i_cfg_valid is high. Registers should only be written
// while no target is in flight.
// A target word is taken at each rising edge with start high and busy low.
// busy never rises, so one target can be sent every cycle.
// Each target yields exactly one result word, shown for a single cycle with
// o_done high: the hit id, in-view flag, distance, unit direction and the
// sweep-end marker. Results come out in input order.
// The path runs through three front stages, one stage per root bit of the square
// root, two compare stages, one stage per quotient bit of the divider and the
// output register.
// Throughput is one word per cycle.
// Synchronous reset clears the registers to their defaults and drops every
// word in flight. The receiver cannot stall; it must take each o_done word.
module view_cone_range_filter #(
    parameter int COORD_BITS    = vcrf_pkg::COORD_BITS_DEF,
    parameter int DIR_FRAC_BITS = vcrf_pkg::DIR_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [vcrf_pkg::ID_BITS-1:0]        i_observer_id,
    input  logic [vcrf_pkg::ID_BITS-1:0]        i_target_id,
    input  logic signed [COORD_BITS-1:0]        i_tgt_x,
    input  logic signed [COORD_BITS-1:0]        i_tgt_y,
    input  logic signed [COORD_BITS-1:0]        i_tgt_z,
    input  logic                                i_last_in,
    output logic                                o_done,
    output logic [vcrf_pkg::ID_BITS-1:0]        o_hit_id,
    output logic                                o_in_view,
    output logic [COORD_BITS:0]                 o_distance,
    output logic signed [DIR_FRAC_BITS+1:0]     o_dir_x,
    output logic signed [DIR_FRAC_BITS+1:0]     o_dir_y,
    output logic signed [DIR_FRAC_BITS+1:0]     o_dir_z,
    output logic                                o_last_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vcrf_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [vcrf_pkg::max2(COORD_BITS+1, DIR_FRAC_BITS+2)-1:0] i_cfg_data
);
    localparam int C      = COORD_BITS;
    localparam int D      = DIR_FRAC_BITS;
    localparam int N      = C + 1;
    localparam int U      = D + 2;
    localparam int IDW    = vcrf_pkg::ID_BITS;
    localparam int DOT_W  = U + N + 2;
    localparam int LIM_W  = U + N + 1;
    localparam int SQ_SIDE_W  = DOT_W + 3 * N + 3 + IDW + 2;
    localparam int DIV_SIDE_W = IDW + 5;
    localparam int LAT    = C + D + 8;

    // Configuration registers.
    logic signed [C-1:0] r_obs_x, r_obs_y, r_obs_z;
    logic signed [U-1:0] r_face_x, r_face_y, r_face_z, r_view_cos;
    logic [N-1:0]        r_range;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_x    <= '0;
            r_obs_y    <= '0;
            r_obs_z    <= '0;
            r_face_x   <= U'(1) << D;
            r_face_y   <= '0;
            r_face_z   <= '0;
            r_range    <= '0;
            r_view_cos <= U'(1) << D;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (vcrf_pkg::t_cfg_reg'(i_cfg_index))
                vcrf_pkg::REG_OBS_X:       r_obs_x    <= i_cfg_data[C-1:0];
                vcrf_pkg::REG_OBS_Y:       r_obs_y    <= i_cfg_data[C-1:0];
                vcrf_pkg::REG_OBS_Z:       r_obs_z    <= i_cfg_data[C-1:0];
                vcrf_pkg::REG_FACE_X:      r_face_x   <= i_cfg_data[U-1:0];
                vcrf_pkg::REG_FACE_Y:      r_face_y   <= i_cfg_data[U-1:0];
                vcrf_pkg::REG_FACE_Z:      r_face_z   <= i_cfg_data[U-1:0];
                vcrf_pkg::REG_RANGE_LIMIT: r_range    <= i_cfg_data[N-1:0];
                vcrf_pkg::REG_VIEW_COS:    r_view_cos <= i_cfg_data[U-1:0];
            endcase
        end
    end

    // Front end: offsets, squares and the facing dot product.
    logic                    fe_valid;
    logic [2*N-1:0]          fe_rad;
    logic signed [DOT_W-1:0] fe_dot;
    logic [N-1:0]            fe_mx, fe_my, fe_mz;
    logic                    fe_nx, fe_ny, fe_nz;
    logic [IDW-1:0]          fe_tid;
    logic                    fe_last, fe_idne;

    vcrf_front #(
        .C (C),
        .U (U)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start && !busy),
        .i_observer_id (i_observer_id),
        .i_target_id   (i_target_id),
        .i_tgt_x       (i_tgt_x),
        .i_tgt_y       (i_tgt_y),
        .i_tgt_z       (i_tgt_z),
        .i_last_in     (i_last_in),
        .i_obs_x       (r_obs_x),
        .i_obs_y       (r_obs_y),
        .i_obs_z       (r_obs_z),
        .i_face_x      (r_face_x),
        .i_face_y      (r_face_y),
        .i_face_z      (r_face_z),
        .o_valid       (fe_valid),
        .o_rad         (fe_rad),
        .o_dot         (fe_dot),
        .o_mag_x       (fe_mx),
        .o_mag_y       (fe_my),
        .o_mag_z       (fe_mz),
        .o_neg_x       (fe_nx),
        .o_neg_y       (fe_ny),
        .o_neg_z       (fe_nz),
        .o_tid         (fe_tid),
        .o_last        (fe_last),
        .o_idne        (fe_idne)
    );

    // Square root of the squared length; everything else rides alongside.
    logic [SQ_SIDE_W-1:0] sq_side_in, sq_side_out;
    logic                 sq_valid;
    logic [N-1:0]         sq_len;

    assign sq_side_in = {fe_dot, fe_mx, fe_my, fe_mz, fe_nx, fe_ny, fe_nz,
                         fe_tid, fe_last, fe_idne};

    vcrf_isqrt #(
        .N      (N),
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fe_valid),
        .i_rad   (fe_rad),
        .i_side  (sq_side_in),
        .o_valid (sq_valid),
        .o_root  (sq_len),
        .o_side  (sq_side_out)
    );

    logic signed [DOT_W-1:0] sq_dot;
    logic [2:0][N-1:0]       sq_mag;
    logic [2:0]              sq_neg;
    logic [IDW-1:0]          sq_tid;
    logic                    sq_last, sq_idne;

    assign {sq_dot, sq_mag, sq_neg, sq_tid, sq_last, sq_idne} = sq_side_out;

    // Stage A: the cone limit view_cos * length and the range test.
    logic                    r_a_vld;
    logic signed [LIM_W-1:0] r_a_lim;
    logic signed [DOT_W-1:0] r_a_dot;
    logic [N-1:0]            r_a_len;
    logic                    r_a_rok, r_a_idne, r_a_last;
    logic [2:0][N-1:0]       r_a_mag;
    logic [2:0]              r_a_neg;
    logic [IDW-1:0]          r_a_tid;

    // Stage B: the in-view decision; the divider starts from here.
    logic                    r_b_vld;
    logic                    r_b_hit, r_b_last;
    logic [N-1:0]            r_b_len;
    logic [2:0][N-1:0]       r_b_mag;
    logic [2:0]              r_b_neg;
    logic [IDW-1:0]          r_b_tid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= sq_valid;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_lim  <= LIM_W'(r_view_cos) * LIM_W'($signed({1'b0, sq_len}));
        r_a_dot  <= sq_dot;
        r_a_len  <= sq_len;
        // A coincident target has zero length and is never in view.
        r_a_rok  <= (sq_len != '0) && (sq_len < r_range);
        r_a_idne <= sq_idne;
        r_a_last <= sq_last;
        r_a_mag  <= sq_mag;
        r_a_neg  <= sq_neg;
        r_a_tid  <= sq_tid;

        r_b_hit  <= r_a_idne && r_a_rok && (r_a_dot > DOT_W'(r_a_lim));
        r_b_last <= r_a_last;
        r_b_len  <= r_a_len;
        r_b_mag  <= r_a_mag;
        r_b_neg  <= r_a_neg;
        r_b_tid  <= r_a_tid;
    end

    // Direction quotients |d| * 2^D / length.
    logic [DIV_SIDE_W-1:0] dv_side_in, dv_side_out;
    logic                  dv_valid;
    logic [N-1:0]          dv_len;
    logic [2:0][D:0]       dv_q;
    logic [2:0][N-1:0]     dv_rem;

    assign dv_side_in = {r_b_tid, r_b_last, r_b_hit, r_b_neg};

    vcrf_div #(
        .N      (N),
        .D      (D),
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .i_len   (r_b_len),
        .i_mag   (r_b_mag),
        .i_side  (dv_side_in),
        .o_valid (dv_valid),
        .o_len   (dv_len),
        .o_q     (dv_q),
        .o_rem   (dv_rem),
        .o_side  (dv_side_out)
    );

    logic [IDW-1:0] dv_tid;
    logic           dv_last, dv_hit;
    logic [2:0]     dv_neg;

    assign {dv_tid, dv_last, dv_hit, dv_neg} = dv_side_out;

    // Round to nearest with ties away from zero, then apply the sign; a zero length gives zero.
    logic [2:0][U-1:0] n_dir;

    always_comb begin
        logic       rnd;
        logic [D:0] qr;
        for (int j = 0; j < 3; j++) begin
            rnd = ({dv_rem[j], 1'b0} >= {1'b0, dv_len});
            qr  = dv_q[j] + (D+1)'(rnd);
            if (dv_len == '0) begin
                n_dir[j] = '0;
            end else if (dv_neg[j]) begin
                n_dir[j] = U'(0) - U'(qr);
            end else begin
                n_dir[j] = U'(qr);
            end
        end
    end

    logic                  r_done;
    logic [IDW-1:0]        r_hit_id;
    logic                  r_in_view, r_last_out;
    logic [N-1:0]          r_distance;
    logic [2:0][U-1:0]     r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_id   <= dv_tid;
        r_in_view  <= dv_hit;
        r_last_out <= dv_last;
        r_distance <= dv_len;
        r_dir      <= n_dir;
    end

    assign o_done     = r_done;
    assign o_hit_id   = r_hit_id;
    assign o_in_view  = r_in_view;
    assign o_last_out = r_last_out;
    assign o_distance = r_distance;
    assign o_dir_x    = r_dir[2];
    assign o_dir_y    = r_dir[1];
    assign o_dir_z    = r_dir[0];

    // A target in view always has a nonzero distance.
    a_view_needs_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_in_view |-> o_distance != '0)
        else $error("in-view result with zero distance");

    // A zero distance gives a zero direction.
    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_distance == '0) |->
            (o_dir_x == '0) && (o_dir_y == '0) && (o_dir_z == '0))
        else $error("nonzero direction for a coincident target");

    // Every result traces back to a target taken through the start handshake.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without a matching accepted target");

endmodule
